// File: sv/trapezoid_motion_profile_macros.svh
// Assertion macros shared by the RTL of the motion profile block.
`ifndef TRAPEZOID_MOTION_PROFILE_MACROS_SVH
`define TRAPEZOID_MOTION_PROFILE_MACROS_SVH

`ifndef NO_ASSERTIONS
`define TMP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define TMP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define TMP_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define TMP_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// File: sv/tmp_pkg.sv
package tmp_pkg;

	localparam int unsigned W = 32;
	localparam logic [W-1:0] ALL_ONES = '1;
	localparam logic [W-1:0] FALLBACK_RESET = 32'h0001_0000;

	localparam logic [2:0] REG_DIST = 3'd0;
	localparam logic [2:0] REG_NOM = 3'd1;
	localparam logic [2:0] REG_FB = 3'd2;
	localparam logic [2:0] REG_ACC = 3'd3;
	localparam logic [2:0] REG_MODE = 3'd4;

	localparam logic [1:0] MODE_NONE = 2'd0;
	localparam logic [1:0] MODE_START = 2'd1;
	localparam logic [1:0] MODE_END = 2'd2;
	localparam logic [1:0] MODE_BOTH = 2'd3;

	typedef struct packed {
		logic start;
		logic [63:0] num;
		logic [32:0] den;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic busy;
		logic [63:0] quot;
	} div_rsp_t;

	function automatic logic [W-1:0] sat32(input logic [63:0] x);
		return (x[63:32] != 32'd0) ? ALL_ONES : x[31:0];
	endfunction

	function automatic logic [W-1:0] qmul(input logic [W-1:0] a, input logic [W-1:0] b);
		logic [63:0] p;
		p = {32'd0, a} * {32'd0, b};
		return sat32({16'd0, p[63:16]});
	endfunction

	function automatic logic [W-1:0] qadd(input logic [W-1:0] a, input logic [W-1:0] b);
		return sat32({32'd0, a} + {32'd0, b});
	endfunction

	function automatic logic [W-1:0] qsub(input logic [W-1:0] a, input logic [W-1:0] b);
		return (a > b) ? (a - b) : 32'd0;
	endfunction

endpackage

// File: sv/tmp_ifs.sv
interface tmp_req_if;
	import tmp_pkg::*;
	logic valid;
	logic ready;
	logic signed [W-1:0] query_time;
	modport source(output valid, output query_time, input ready);
	modport sink(input valid, input query_time, output ready);
endinterface

interface tmp_rsp_if;
	import tmp_pkg::*;
	logic valid;
	logic ready;
	logic [W-1:0] position;
	logic [W-1:0] speed;
	logic [W-1:0] travel_time;
	logic plan_error;
	modport source(output valid, output position, output speed, output travel_time,
		output plan_error, input ready);
	modport sink(input valid, input position, input speed, input travel_time,
		input plan_error, output ready);
endinterface

// File: sv/tmp_div.sv
module tmp_div (
	input logic clk,
	input logic arst_n,
	input tmp_pkg::div_req_t req,
	output tmp_pkg::div_rsp_t rsp
);
	import tmp_pkg::*;

	logic [33:0] rem_q;
	logic [63:0] quo_q;
	logic [32:0] den_q;
	logic [5:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [33:0] rem_sh;
	logic fits;

	assign rem_sh = {rem_q[32:0], quo_q[63]};
	assign fits = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.num;
			den_q <= req.den;
		end else if (busy_q) begin
			rem_q <= fits ? (rem_sh - {1'b0, den_q}) : rem_sh;
			quo_q <= {quo_q[62:0], fits};
		end
	end

	assign rsp.done = done_q;
	assign rsp.busy = busy_q;
	assign rsp.quot = quo_q;

endmodule

// File: sv/trapezoid_motion_profile.sv
// Trapezoidal velocity profile evaluator for one axis.
// Registers are written over the APB port: travel distance at 0x00, nominal speed
// at 0x04, fallback speed at 0x08, acceleration at 0x0C and ramp mode at 0x10.
// pready is always high and a read returns the register value.
// After reset and after every register write a plan sequencer works out the
// phase times and peak speed with a shared bit-serial divider, which gives up to
// three quotients, and a serial square root. While it runs, req.ready stays low.
// Once the plan is ready each query time on req gives one word on rsp holding
// position, speed, total travel time and the plan error flag.
// The evaluation pipeline has five register stages, and a new query may enter every
// cycle while no replan runs and rsp.ready does not hold the pipeline.
// Each stage keeps its own valid bit; when rsp.ready is low the last stage holds
// its word and earlier stages keep filling until the pipeline is full.
// Reset restores the register defaults and starts a replan.
`include "trapezoid_motion_profile_macros.svh"

module trapezoid_motion_profile (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [4:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	tmp_req_if.sink req,
	tmp_rsp_if.source rsp
);
	import tmp_pkg::*;

	localparam logic [2:0] P_IDLE = 3'd0;
	localparam logic [2:0] P_START = 3'd1;
	localparam logic [2:0] P_TA = 3'd2;
	localparam logic [2:0] P_DA = 3'd3;
	localparam logic [2:0] P_MAIN = 3'd4;
	localparam logic [2:0] P_TRI = 3'd5;
	localparam logic [2:0] P_SQRT = 3'd6;
	localparam logic [2:0] P_PEAK = 3'd7;

	logic [W-1:0] dist_q, nom_q, fb_q, acc_q;
	logic [1:0] mode_q;
	logic wr_en;

	logic [2:0] pst_q;
	logic replan_q;
	logic busy;
	logic div_start_q;
	logic [63:0] div_num_q;
	logic [32:0] div_den_q;
	div_req_t div_req;
	div_rsp_t div_rsp;

	logic [W-1:0] v_c;
	logic ramped_c;
	logic [W-1:0] v_q, ta_q, qd_c;
	logic [63:0] vv_q, da_c;
	logic ramped_q, err_q;
	logic [W-1:0] t1_q, t2_q, tend_q, vinit_q, vpeak_q, vfinal_q;
	logic [47:0] sq_x_q;
	logic [26:0] sq_rem_q, sq_rem_n, sq_trial;
	logic [23:0] sq_root_q, sq_root_n;
	logic [4:0] sq_cnt_q;
	logic [23:0] tm_q;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dist_q <= '0;
			nom_q <= '0;
			fb_q <= FALLBACK_RESET;
			acc_q <= '0;
			mode_q <= MODE_NONE;
		end else if (wr_en) begin
			case (paddr[4:2])
				REG_DIST: dist_q <= pwdata;
				REG_NOM: nom_q <= pwdata;
				REG_FB: fb_q <= pwdata;
				REG_ACC: acc_q <= pwdata;
				REG_MODE: mode_q <= pwdata[1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			REG_DIST: prdata = dist_q;
			REG_NOM: prdata = nom_q;
			REG_FB: prdata = fb_q;
			REG_ACC: prdata = acc_q;
			REG_MODE: prdata = {30'd0, mode_q};
			default: prdata = '0;
		endcase
	end

	assign div_req = {div_start_q, div_num_q, div_den_q};

	tmp_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.req(div_req),
		.rsp(div_rsp)
	);

	assign v_c = (nom_q != '0) ? nom_q : fb_q;
	assign ramped_c = (acc_q != '0) && (mode_q != MODE_NONE);
	assign qd_c = sat32(div_rsp.quot);
	assign da_c = div_rsp.quot;
	assign busy = (pst_q != P_IDLE) || replan_q;

	assign sq_rem_n = {sq_rem_q[24:0], sq_x_q[47:46]};
	assign sq_trial = {1'b0, sq_root_q, 2'b01};
	assign sq_root_n = {sq_root_q[22:0], sq_rem_n >= sq_trial};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pst_q <= P_IDLE;
			replan_q <= 1'b1;
			div_start_q <= 1'b0;
		end else begin
			div_start_q <= 1'b0;
			if (wr_en)
				replan_q <= 1'b1;
			else if (pst_q == P_IDLE && replan_q)
				replan_q <= 1'b0;
			case (pst_q)
				P_IDLE: if (replan_q) pst_q <= P_START;
				P_START: begin
					if (ramped_c ? (dist_q == '0) : (dist_q == '0)) begin
						pst_q <= P_IDLE;
					end else begin
						div_start_q <= 1'b1;
						pst_q <= ramped_c ? P_TA : P_MAIN;
					end
				end
				P_TA: if (div_rsp.done) begin
					div_start_q <= 1'b1;
					pst_q <= P_DA;
				end
				P_DA: if (div_rsp.done) begin
					if (mode_q != MODE_BOTH && da_c > {32'd0, dist_q}) begin
						pst_q <= P_IDLE;
					end else begin
						div_start_q <= 1'b1;
						pst_q <= (mode_q == MODE_BOTH && {da_c, 1'b0} > {33'd0, dist_q})
							? P_TRI : P_MAIN;
					end
				end
				P_MAIN: if (div_rsp.done) pst_q <= P_IDLE;
				P_TRI: if (div_rsp.done) pst_q <= P_SQRT;
				P_SQRT: if (sq_cnt_q == 5'd23) pst_q <= P_PEAK;
				P_PEAK: pst_q <= P_IDLE;
				default: pst_q <= P_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (pst_q)
			P_START: begin
				v_q <= v_c;
				vv_q <= {32'd0, v_c} * {32'd0, v_c};
				ramped_q <= ramped_c;
				err_q <= 1'b0;
				t1_q <= '0;
				t2_q <= '0;
				tend_q <= '0;
				vinit_q <= ramped_c ? '0 : v_c;
				vpeak_q <= ramped_c ? '0 : v_c;
				vfinal_q <= ramped_c ? '0 : v_c;
				div_num_q <= ramped_c ? {16'd0, v_c, 16'd0} : {16'd0, dist_q, 16'd0};
				div_den_q <= ramped_c ? {1'b0, acc_q} : {1'b0, v_c};
			end
			P_TA: if (div_rsp.done) begin
				ta_q <= qd_c;
				div_num_q <= vv_q;
				div_den_q <= {acc_q, 1'b0};
			end
			P_DA: if (div_rsp.done) begin
				if (mode_q != MODE_BOTH && da_c > {32'd0, dist_q})
					err_q <= 1'b1;
				if (mode_q != MODE_BOTH) begin
					div_num_q <= {16'd0, dist_q - da_c[31:0], 16'd0};
					div_den_q <= {1'b0, v_q};
				end else if ({da_c, 1'b0} > {33'd0, dist_q}) begin
					div_num_q <= {16'd0, dist_q, 16'd0};
					div_den_q <= {1'b0, acc_q};
				end else begin
					div_num_q <= {16'd0, dist_q - {da_c[30:0], 1'b0}, 16'd0};
					div_den_q <= {1'b0, v_q};
				end
			end
			P_MAIN: if (div_rsp.done) begin
				if (!ramped_q) begin
					tend_q <= qd_c;
					t2_q <= qd_c;
				end else begin
					case (mode_q)
						MODE_START: begin
							t1_q <= ta_q;
							t2_q <= qadd(ta_q, qd_c);
							tend_q <= qadd(ta_q, qd_c);
							vpeak_q <= v_q;
							vfinal_q <= v_q;
						end
						MODE_END: begin
							t2_q <= qd_c;
							tend_q <= qadd(qd_c, ta_q);
							vinit_q <= v_q;
							vpeak_q <= v_q;
						end
						default: begin
							t1_q <= ta_q;
							t2_q <= qadd(ta_q, qd_c);
							tend_q <= qadd(qadd(ta_q, qd_c), ta_q);
							vpeak_q <= v_q;
						end
					endcase
				end
			end
			P_TRI: if (div_rsp.done) begin
				sq_x_q <= {qd_c, 16'd0};
				sq_rem_q <= '0;
				sq_root_q <= '0;
				sq_cnt_q <= '0;
			end
			P_SQRT: begin
				sq_x_q <= {sq_x_q[45:0], 2'b00};
				sq_rem_q <= (sq_rem_n >= sq_trial) ? (sq_rem_n - sq_trial) : sq_rem_n;
				sq_root_q <= sq_root_n;
				sq_cnt_q <= sq_cnt_q + 5'd1;
				tm_q <= sq_root_n;
			end
			P_PEAK: begin
				t1_q <= {8'd0, tm_q};
				t2_q <= {8'd0, tm_q};
				tend_q <= qadd({8'd0, tm_q}, {8'd0, tm_q});
				vpeak_q <= qmul(acc_q, {8'd0, tm_q});
			end
			default: ;
		endcase
	end

	// Evaluation pipeline.
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic en1, en2, en3, en4, en5;
	logic [W-1:0] raw_s1, time1_s1, time2_s1, time3_s1;
	logic neg_s1, over_s1, gt1_s1, gt2_s1;
	logic [W-1:0] time1_s2, time3_s2, mv1_s2, ma1_s2, mv2_s2, mp3_s2, ma3_s2, lin_s2;
	logic neg_s2, over_s2, gt1_s2, gt2_s2;
	logic [W-1:0] mv1_s3, ma1_s3, mv2_s3, mp3_s3, ma3_s3, lin_s3, h1_s3, h3_s3;
	logic neg_s3, over_s3, gt1_s3, gt2_s3;
	logic [W-1:0] pb_s4, spd_s4, mp3_s4, h3_s4, lin_s4;
	logic neg_s4, over_s4, gt2_s4;
	logic [W-1:0] pos_s5, spd_s5, tt_s5;
	logic err_s5;
	logic [W-1:0] raw_in;
	logic [63:0] hp1, hp3;
	logic [W-1:0] pos_tail;

	assign en5 = !vld_s5 || rsp.ready;
	assign en4 = !vld_s4 || en5;
	assign en3 = !vld_s3 || en4;
	assign en2 = !vld_s2 || en3;
	assign en1 = !vld_s1 || en2;
	assign req.ready = en1 && !busy;
	assign raw_in = req.query_time;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (en1) vld_s1 <= req.valid && !busy;
			if (en2) vld_s2 <= vld_s1;
			if (en3) vld_s3 <= vld_s2;
			if (en4) vld_s4 <= vld_s3;
			if (en5) vld_s5 <= vld_s4;
		end
	end

	assign hp1 = {32'd0, ma1_s2} * {32'd0, time1_s2};
	assign hp3 = {32'd0, ma3_s2} * {32'd0, time3_s2};
	assign pos_tail = gt2_s4 ? qsub(qadd(pb_s4, mp3_s4), h3_s4) : pb_s4;

	always_ff @(posedge clk) begin
		if (en1) begin
			raw_s1 <= raw_in;
			neg_s1 <= raw_in[W-1];
			over_s1 <= raw_in > tend_q;
			gt1_s1 <= raw_in > t1_q;
			gt2_s1 <= raw_in > t2_q;
			time1_s1 <= (raw_in > t1_q) ? t1_q : raw_in;
			time2_s1 <= (raw_in > t1_q) ? (((raw_in > t2_q) ? t2_q : raw_in) - t1_q) : '0;
			time3_s1 <= (raw_in > t2_q) ? (raw_in - t2_q) : '0;
		end
		if (en2) begin
			time1_s2 <= time1_s1;
			time3_s2 <= time3_s1;
			mv1_s2 <= qmul(vinit_q, time1_s1);
			ma1_s2 <= qmul(acc_q, time1_s1);
			mv2_s2 <= qmul(v_q, time2_s1);
			mp3_s2 <= qmul(vpeak_q, time3_s1);
			ma3_s2 <= qmul(acc_q, time3_s1);
			lin_s2 <= qmul(v_q, raw_s1);
			neg_s2 <= neg_s1;
			over_s2 <= over_s1;
			gt1_s2 <= gt1_s1;
			gt2_s2 <= gt2_s1;
		end
		if (en3) begin
			h1_s3 <= sat32({17'd0, hp1[63:17]});
			h3_s3 <= sat32({17'd0, hp3[63:17]});
			mv1_s3 <= mv1_s2;
			ma1_s3 <= ma1_s2;
			mv2_s3 <= mv2_s2;
			mp3_s3 <= mp3_s2;
			ma3_s3 <= ma3_s2;
			lin_s3 <= lin_s2;
			neg_s3 <= neg_s2;
			over_s3 <= over_s2;
			gt1_s3 <= gt1_s2;
			gt2_s3 <= gt2_s2;
		end
		if (en4) begin
			pb_s4 <= qadd(qadd(mv1_s3, h1_s3), gt1_s3 ? mv2_s3 : '0);
			spd_s4 <= gt2_s3 ? qsub(vpeak_q, ma3_s3) :
				(gt1_s3 ? vpeak_q : qadd(vinit_q, ma1_s3));
			mp3_s4 <= mp3_s3;
			h3_s4 <= h3_s3;
			lin_s4 <= lin_s3;
			neg_s4 <= neg_s3;
			over_s4 <= over_s3;
			gt2_s4 <= gt2_s3;
		end
		if (en5) begin
			err_s5 <= err_q;
			tt_s5 <= err_q ? '0 : tend_q;
			if (err_q) begin
				pos_s5 <= '0;
				spd_s5 <= '0;
			end else if (neg_s4) begin
				pos_s5 <= '0;
				spd_s5 <= vinit_q;
			end else if (over_s4) begin
				pos_s5 <= dist_q;
				spd_s5 <= vfinal_q;
			end else if (!ramped_q) begin
				pos_s5 <= lin_s4;
				spd_s5 <= v_q;
			end else begin
				pos_s5 <= pos_tail;
				spd_s5 <= spd_s4;
			end
		end
	end

	assign rsp.valid = vld_s5;
	assign rsp.position = pos_s5;
	assign rsp.speed = spd_s5;
	assign rsp.travel_time = tt_s5;
	assign rsp.plan_error = err_s5;

	`TMP_ASSERT_IMP(a_no_accept_busy, clk, arst_n, req.valid && req.ready, !busy)
	`TMP_ASSERT_IMP(a_err_zero, clk, arst_n, rsp.valid && rsp.plan_error,
		rsp.position == '0 && rsp.speed == '0 && rsp.travel_time == '0)
	`TMP_ASSERT_IMP(a_div_idle, clk, arst_n, div_start_q, !div_rsp.busy)
	`TMP_ASSERT_NXT(a_s4_to_s5, clk, arst_n, vld_s4 && en5, vld_s5)

endmodule

// File: tb/sv/trapezoid_motion_profile_test.sv
`timescale 1ns / 100ps

module trapezoid_motion_profile_test;
	import tmp_pkg::*;

	localparam logic [2:0] REG_SPARE = 3'd5;

	typedef struct {
		logic [31:0] t1, t2, tend, vinit, vpeak, vfinal;
		bit ramped, err;
	} plan_s;

	typedef struct {
		logic [31:0] position, speed, travel_time;
		logic plan_error;
	} motion_s;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [4:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	tmp_req_if req ();
	tmp_rsp_if rsp ();

	trapezoid_motion_profile dut (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
		.req(req.sink), .rsp(rsp.source)
	);

	logic [31:0] dist_r, nom_r, fb_r, acc_r;
	logic [1:0] mode_r;
	plan_s cur_plan;
	motion_s expected_motion[$];
	int mismatches = 0, words_checked = 0, items_sent = 0, settings_used = 0;
	int send_idle_pct = 0, recv_stall_pct = 0;

	always #5 clk = ~clk;

	initial begin
		#50ms;
		$display("Timeout");
		$display("Mismatches found");
		$finish;
	end

	function automatic logic [31:0] clip(logic [63:0] x);
		return (x > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : x[31:0];
	endfunction

	function automatic logic [31:0] fx_mul(logic [31:0] a, logic [31:0] b);
		logic [63:0] p;
		p = {32'd0, a} * {32'd0, b};
		return clip(p >> 16);
	endfunction

	function automatic logic [31:0] fx_div(logic [31:0] a, logic [31:0] b);
		if (b == 0)
			return 32'hFFFF_FFFF;
		return clip(({32'd0, a} << 16) / {32'd0, b});
	endfunction

	function automatic logic [31:0] fx_add(logic [31:0] a, logic [31:0] b);
		return clip({32'd0, a} + {32'd0, b});
	endfunction

	function automatic logic [31:0] fx_sub(logic [31:0] a, logic [31:0] b);
		return (a > b) ? a - b : 32'd0;
	endfunction

	function automatic logic [31:0] ramp_distance(logic [31:0] a, logic [31:0] t);
		logic [63:0] p;
		p = {32'd0, fx_mul(a, t)} * {32'd0, t};
		return clip(p >> 17);
	endfunction

	function automatic logic [31:0] fx_root(logic [31:0] x);
		logic [63:0] rem, root, bitv;
		rem = {32'd0, x} << 16;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > rem)
			bitv >>= 2;
		while (bitv != 0) begin
			if (rem >= root + bitv) begin
				rem -= root + bitv;
				root = (root >> 1) + bitv;
			end else begin
				root >>= 1;
			end
			bitv >>= 2;
		end
		return clip(root);
	endfunction

	function automatic logic [31:0] cruise_speed();
		return (nom_r != 0) ? nom_r : fb_r;
	endfunction

	function automatic plan_s plan_move();
		plan_s p;
		logic [31:0] v, ta, tm;
		logic [63:0] da;
		v = cruise_speed();
		p = '{default: 0};
		p.ramped = (acc_r != 0) && (mode_r != MODE_NONE);
		if (!p.ramped) begin
			p.vinit = v;
			p.vpeak = v;
			p.vfinal = v;
			if (dist_r != 0) begin
				p.tend = fx_div(dist_r, v);
				p.t2 = p.tend;
			end
			return p;
		end
		if (dist_r == 0)
			return p;
		ta = fx_div(v, acc_r);
		da = ({32'd0, v} * {32'd0, v}) / ({32'd0, acc_r} * 64'd2);
		if (mode_r == MODE_START) begin
			if (da > dist_r) begin
				p.err = 1;
				return p;
			end
			p.t1 = ta;
			p.tend = fx_add(ta, fx_div(dist_r - da[31:0], v));
			p.t2 = p.tend;
			p.vpeak = v;
			p.vfinal = v;
		end else if (mode_r == MODE_END) begin
			if (da > dist_r) begin
				p.err = 1;
				return p;
			end
			p.t2 = fx_div(dist_r - da[31:0], v);
			p.tend = fx_add(p.t2, ta);
			p.vinit = v;
			p.vpeak = v;
		end else if (2 * da <= dist_r) begin
			p.t1 = ta;
			p.t2 = fx_add(ta, fx_div(dist_r - 32'(2 * da), v));
			p.tend = fx_add(p.t2, ta);
			p.vpeak = v;
		end else begin
			tm = fx_root(fx_div(dist_r, acc_r));
			p.t1 = tm;
			p.t2 = tm;
			p.tend = fx_add(tm, tm);
			p.vpeak = fx_mul(acc_r, tm);
		end
		return p;
	endfunction

	function automatic motion_s motion_at(logic [31:0] t);
		motion_s m;
		plan_s p;
		logic [31:0] v, tp1, tp2, tp3;
		p = cur_plan;
		v = cruise_speed();
		m.position = 0;
		m.speed = 0;
		if (p.err) begin
		end else if (t[31]) begin
			m.speed = p.vinit;
		end else if (t > p.tend) begin
			m.position = dist_r;
			m.speed = p.vfinal;
		end else if (!p.ramped) begin
			m.position = fx_mul(v, t);
			m.speed = v;
		end else begin
			tp1 = (t <= p.t1) ? t : p.t1;
			m.position = fx_add(fx_mul(p.vinit, tp1), ramp_distance(acc_r, tp1));
			m.speed = fx_add(p.vinit, fx_mul(acc_r, tp1));
			if (t > p.t1) begin
				tp2 = ((t <= p.t2) ? t : p.t2) - p.t1;
				m.position = fx_add(m.position, fx_mul(v, tp2));
				m.speed = p.vpeak;
			end
			if (t > p.t2) begin
				tp3 = t - p.t2;
				m.position = fx_sub(fx_add(m.position, fx_mul(p.vpeak, tp3)),
					ramp_distance(acc_r, tp3));
				m.speed = fx_sub(p.vpeak, fx_mul(acc_r, tp3));
			end
		end
		m.travel_time = p.err ? 32'd0 : p.tend;
		m.plan_error = p.err;
		return m;
	endfunction

	task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
		$display("%0t: %s is %h, expected %h", $realtime, field, got, want);
		mismatches++;
	endtask

	always @(posedge clk) begin
		motion_s m;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (expected_motion.size() == 0) begin
				report_mismatch("unexpected word, position", rsp.position, 32'd0);
			end else begin
				m = expected_motion.pop_front();
				words_checked++;
				if (rsp.position !== m.position)
					report_mismatch("position", rsp.position, m.position);
				if (rsp.speed !== m.speed)
					report_mismatch("speed", rsp.speed, m.speed);
				if (rsp.travel_time !== m.travel_time)
					report_mismatch("travel_time", rsp.travel_time, m.travel_time);
				if (rsp.plan_error !== m.plan_error)
					report_mismatch("plan_error", {31'd0, rsp.plan_error},
						{31'd0, m.plan_error});
			end
		end
	end

	always @(negedge clk)
		rsp.ready <= ($urandom_range(99) >= recv_stall_pct);

	task automatic send_query(logic [31:0] t);
		while ($urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			req.valid <= 1'b0;
		end
		@(negedge clk);
		req.valid <= 1'b1;
		req.query_time <= t;
		do
			@(posedge clk);
		while (!req.ready);
		expected_motion.push_back(motion_at(t));
		items_sent++;
	endtask

	task automatic drain();
		@(negedge clk);
		req.valid <= 1'b0;
		wait (expected_motion.size() == 0);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_DIST: dist_r = value;
			REG_NOM: nom_r = value;
			REG_FB: fb_r = value;
			REG_ACC: acc_r = value;
			REG_MODE: mode_r = value[1:0];
			default: ;
		endcase
		cur_plan = plan_move();
	endtask

	task automatic setup_move(logic [31:0] d, logic [31:0] v, logic [31:0] a, logic [1:0] m);
		drain();
		write_reg(REG_DIST, d);
		write_reg(REG_NOM, v);
		write_reg(REG_ACC, a);
		write_reg(REG_MODE, m);
		settings_used++;
	endtask

	function automatic logic [31:0] pick_time();
		logic [63:0] span;
		int k;
		k = $urandom_range(99);
		span = {32'd0, cur_plan.tend} + (cur_plan.tend >> 3) + 64'd2;
		if (span > 64'h7FFF_FFFF)
			span = 64'h7FFF_FFFF;
		if (k < 6)
			return $urandom | 32'h8000_0000;
		if (k < 10)
			return $urandom;
		if (k < 14)
			return cur_plan.tend + $urandom_range(1, 0);
		return $urandom_range(span[31:0], 0);
	endfunction

	function automatic logic [31:0] pick_magnitude();
		return $urandom >> $urandom_range(31, 0);
	endfunction

	task automatic test_directed();
		logic [31:0] times[5] = '{32'd0, 32'd1, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF};
		foreach (times[i])
			send_query(times[i]);
		setup_move(32'h0010_0000, 32'h0002_0000, 32'h0001_0000, MODE_BOTH);
		for (int i = 0; i < 4; i++)
			send_query(32'h0001_0000 * i + 32'h8000);
		setup_move(32'h0001_0000, 32'h0004_0000, 32'h0001_0000, MODE_BOTH);
		send_query(32'h0000_8000);
		send_query(32'h0001_8000);
		setup_move(32'h0001_0000, 32'h0004_0000, 32'h0001_0000, MODE_START);
		send_query(32'h0000_4000);
		setup_move(32'h0001_0000, 32'h0004_0000, 32'h0001_0000, MODE_END);
		send_query(32'h0000_4000);
		setup_move(32'h0000_0000, 32'h0002_0000, 32'h0001_0000, MODE_END);
		send_query(32'h0000_4000);
		setup_move(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, MODE_START);
		send_query(32'h7FFF_FFFF);
		send_query(32'h0000_0001);
		setup_move(32'h0003_0000, 32'd0, 32'd0, MODE_NONE);
		send_query(32'h0001_0000);
		drain();
		write_reg(REG_FB, 32'd0);
		write_reg(REG_SPARE, 32'hFFFF_FFFF);
		send_query(32'h0001_0000);
		drain();
		write_reg(REG_FB, 32'h0003_0000);
		send_query(32'h0001_0000);
	endtask

	task automatic test_random_profiles(int n_settings, int per_setting);
		int idle_s[4] = '{0, 80, 0, 15};
		int idle_r[4] = '{0, 0, 80, 15};
		for (int s = 0; s < n_settings; s++) begin
			send_idle_pct = idle_s[s % 4];
			recv_stall_pct = idle_r[s % 4];
			setup_move(pick_magnitude(), ($urandom_range(9) == 0) ? 32'd0 : pick_magnitude(),
				pick_magnitude(), 2'($urandom_range(3)));
			if ($urandom_range(7) == 0)
				write_reg(REG_FB, pick_magnitude());
			for (int i = 0; i < per_setting; i++)
				send_query(pick_time());
		end
	endtask

	initial begin
		req.valid = 1'b0;
		req.query_time = '0;
		rsp.ready = 1'b0;
		dist_r = 0;
		nom_r = 0;
		fb_r = FALLBACK_RESET;
		acc_r = 0;
		mode_r = MODE_NONE;
		cur_plan = plan_move();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_random_profiles(48, 36);
		drain();
		$display("Sent %0d query times over %0d profile settings; %0d words checked.",
			items_sent, settings_used, words_checked);
		$display("All ramp modes, triangular moves, zero speed and clamped times were covered.");
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// File: files.f
+incdir+sv
sv/tmp_pkg.sv
sv/tmp_ifs.sv
sv/tmp_div.sv
sv/trapezoid_motion_profile.sv
tb/sv/trapezoid_motion_profile_test.sv
